// ----- design/stc_pkg.sv -----
// Shared types and constants for the spectral-to-XYZ tristimulus block.
// Sizes the accumulators from the longest spectrum. No dependencies.
package stc_pkg;

	// Longest spectrum the accumulators are sized for
	localparam int MAX_SAMPLES = 64;
	localparam int CNT_W       = $clog2(MAX_SAMPLES);

	// Product sums: Q1.15 * Q9.7 * Q2.14 -> 48 bits per term
	localparam int PROD_W = 48;
	localparam int SUM_W  = CNT_W + PROD_W;
	// Normalizer: Q2.14 * Q9.7 -> 32 bits per term
	localparam int TERM_W = 32;
	localparam int NORM_W = CNT_W + TERM_W;

	// Saturation caps: MAX_SAMPLES * 65535^3 and MAX_SAMPLES * 65535^2
	localparam logic [63:0] CAP_PROD64 = 64'(MAX_SAMPLES) * 64'd281462092005375;
	localparam logic [63:0] CAP_NORM64 = 64'(MAX_SAMPLES) * 64'd4294836225;
	localparam logic [SUM_W-1:0]  CAP_PROD = CAP_PROD64[SUM_W-1:0];
	localparam logic [NORM_W-1:0] CAP_NORM = CAP_NORM64[NORM_W-1:0];

	// Divider datapath: 100 * sum + 64 * norm, compared against norm << 23
	localparam int DIV_W = SUM_W + 7;

	// Queue between accumulator and divider
	localparam int FIFO_DEPTH = 2;

	localparam int OUT_W = 16;

	// One finished spectrum, waiting for the divider
	typedef struct packed {
		logic [SUM_W-1:0]  sum_x;
		logic [SUM_W-1:0]  sum_y;
		logic [SUM_W-1:0]  sum_z;
		logic [NORM_W-1:0] sum_norm;
	} sums_t;

	// Queue status seen by its two sides
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ----- design/stc_front.sv -----
// Front end: multiplies each wavelength sample and accumulates the sums.
// Pushes the finished sums into the queue on the last sample. Uses stc_pkg.
module stc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [79:0]         s_tdata,   // reflectance, illuminant, observer_x, _y, _z
	input  logic                s_tlast,   // last_sample
	input  stc_pkg::fifo_stat_t q_stat,
	output logic                push,
	output stc_pkg::sums_t      push_data
);
	import stc_pkg::*;

	logic [15:0] refl, illum, obs_x, obs_y, obs_z;

	logic              v_s1, last_s1;
	logic [31:0]       ri_s1, nt_s1;
	logic [15:0]       ox_s1, oy_s1, oz_s1;

	logic              v_s2, last_s2;
	logic [PROD_W-1:0] px_s2, py_s2, pz_s2;
	logic [TERM_W-1:0] nt_s2;

	logic [SUM_W-1:0]  sum_x_q, sum_y_q, sum_z_q;
	logic [NORM_W-1:0] sum_norm_q;

	logic              advance;
	sums_t             nxt;

	function automatic logic [SUM_W-1:0] sat_prod(input logic [SUM_W-1:0] acc,
			input logic [PROD_W-1:0] add);
		logic [SUM_W:0] s;
		s = {1'b0, acc} + (SUM_W+1)'(add);
		return (s > {1'b0, CAP_PROD}) ? CAP_PROD : s[SUM_W-1:0];
	endfunction

	function automatic logic [NORM_W-1:0] sat_norm(input logic [NORM_W-1:0] acc,
			input logic [TERM_W-1:0] add);
		logic [NORM_W:0] s;
		s = {1'b0, acc} + (NORM_W+1)'(add);
		return (s > {1'b0, CAP_NORM}) ? CAP_NORM : s[NORM_W-1:0];
	endfunction

	assign refl  = s_tdata[15:0];
	assign illum = s_tdata[31:16];
	assign obs_x = s_tdata[47:32];
	assign obs_y = s_tdata[63:48];
	assign obs_z = s_tdata[79:64];

	// Stall the whole pipe only when a finished spectrum cannot enter the queue
	assign advance  = !(v_s2 && last_s2 && q_stat.full);
	assign s_tready = advance;

	// Next sums including the item in the last stage
	always_comb begin
		nxt.sum_x    = sat_prod(sum_x_q, px_s2);
		nxt.sum_y    = sat_prod(sum_y_q, py_s2);
		nxt.sum_z    = sat_prod(sum_z_q, pz_s2);
		nxt.sum_norm = sat_norm(sum_norm_q, nt_s2);
	end

	assign push      = v_s2 && last_s2 && advance;
	assign push_data = nxt;

	// Stage valids and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			sum_x_q    <= '0;
			sum_y_q    <= '0;
			sum_z_q    <= '0;
			sum_norm_q <= '0;
		end else if (advance) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			if (v_s2) begin
				if (last_s2) begin
					sum_x_q    <= '0;
					sum_y_q    <= '0;
					sum_z_q    <= '0;
					sum_norm_q <= '0;
				end else begin
					sum_x_q    <= nxt.sum_x;
					sum_y_q    <= nxt.sum_y;
					sum_z_q    <= nxt.sum_z;
					sum_norm_q <= nxt.sum_norm;
				end
			end
		end
	end

	// Multiplier stages: first the illuminant products, then the observer weights
	always_ff @(posedge clk) begin
		if (advance) begin
			ri_s1   <= refl * illum;
			nt_s1   <= obs_y * illum;
			ox_s1   <= obs_x;
			oy_s1   <= obs_y;
			oz_s1   <= obs_z;
			last_s1 <= s_tlast;

			px_s2   <= ri_s1 * ox_s1;
			py_s2   <= ri_s1 * oy_s1;
			pz_s2   <= ri_s1 * oz_s1;
			nt_s2   <= nt_s1;
			last_s2 <= last_s1;
		end
	end

endmodule

// ----- design/stc_fifo.sv -----
// Short queue of finished spectrum sums between front end and divider.
// Register-based, depth from stc_pkg::FIFO_DEPTH. Uses stc_pkg.
module stc_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  stc_pkg::sums_t      push_data,
	input  logic                pop,
	output stc_pkg::sums_t      head,
	output stc_pkg::fifo_stat_t stat
);
	import stc_pkg::*;

	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	sums_t         mem_q [FIFO_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	assign stat.full  = (cnt_q == (AW+1)'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = mem_q[rd_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

// ----- design/stc_back.sv -----
// Back end: scales each sum to Q8.8 by 100 / normalizer with a restoring divider.
// Reads spectra from the queue and drives the result register. Uses stc_pkg.
module stc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  stc_pkg::sums_t      head,
	input  stc_pkg::fifo_stat_t q_stat,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [47:0]         m_tdata,   // tri_x, tri_y, tri_z
	output logic [1:0]          m_tuser    // norm_zero, clipped
);
	import stc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_CHECK,
		ST_ITER,
		ST_DONE
	} state_t;

	localparam logic [1:0] CH_LAST = 2'd2;

	state_t           state_q;
	sums_t            ent_q;
	logic [1:0]       ch_q;
	logic [3:0]       cnt_q;
	logic [DIV_W-1:0] rem_q, dsh_q;
	logic [OUT_W-1:0] quo_q;
	logic [OUT_W-1:0] res_q [3];
	logic             clip_q, nz_q;

	logic [SUM_W-1:0] sel;
	logic             ge;

	// Pick the channel being divided
	always_comb begin
		case (ch_q)
			2'd0:    sel = ent_q.sum_x;
			2'd1:    sel = ent_q.sum_y;
			default: sel = ent_q.sum_z;
		endcase
	end

	assign ge  = (rem_q >= dsh_q);
	assign pop = (state_q == ST_IDLE) && !q_stat.empty;

	// Sequencer, divider datapath and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			// Free the output register once its transfer completes
			if (m_tvalid && m_tready && state_q != ST_DONE)
				m_tvalid <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						ent_q  <= head;
						ch_q   <= '0;
						clip_q <= 1'b0;
						if (head.sum_norm == '0) begin
							// Zero normalizer: all outputs zero, flag it
							res_q[0] <= '0;
							res_q[1] <= '0;
							res_q[2] <= '0;
							nz_q     <= 1'b1;
							state_q  <= ST_DONE;
						end else begin
							nz_q    <= 1'b0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					// Numerator, first half: 96 * sum
					rem_q   <= DIV_W'({sel, 6'b0}) + DIV_W'({sel, 5'b0});
					dsh_q   <= DIV_W'({ent_q.sum_norm, 23'b0});
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					// Add 4 * sum and half the divisor for round-to-nearest
					rem_q   <= rem_q + DIV_W'({sel, 2'b0}) + DIV_W'({ent_q.sum_norm, 6'b0});
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (ge) begin
						// Quotient does not fit 16 bits: saturate
						res_q[ch_q] <= '1;
						clip_q      <= 1'b1;
						if (ch_q == CH_LAST) begin
							state_q <= ST_DONE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_MUL;
						end
					end else begin
						dsh_q   <= dsh_q >> 1;
						cnt_q   <= '0;
						state_q <= ST_ITER;
					end
				end
				ST_ITER: begin
					// One quotient bit per cycle, most significant first
					if (ge)
						rem_q <= rem_q - dsh_q;
					dsh_q <= dsh_q >> 1;
					quo_q <= {quo_q[OUT_W-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'(OUT_W - 1)) begin
						res_q[ch_q] <= {quo_q[OUT_W-2:0], ge};
						if (ch_q == CH_LAST) begin
							state_q <= ST_DONE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_DONE: begin
					// Hand the result over once the output register is free
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {res_q[2], res_q[1], res_q[0]};
						m_tuser  <= {clip_q, nz_q};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- design/spectral_to_xyz_tristimulus.sv -----
// Top level of the spectral reflectance to CIE XYZ tristimulus block.
// Instantiates stc_front, stc_fifo and stc_back; uses stc_pkg.
//
// Usage:
//   Input stream: one wavelength sample per transfer. s_tdata carries
//   reflectance, illuminant and the three observer weights; s_tlast marks
//   the last sample of a spectrum. Output stream: one transfer per spectrum
//   with X, Y, Z in Q8.8 on m_tdata and the norm_zero / clipped flags on
//   m_tuser, scaled so that a perfect reflector gives Y = 100.
//   Throughput: one sample per cycle. The front end is a two-stage multiply
//   pipeline plus saturating accumulators; finished sums enter a two-entry
//   queue. The back end is a restoring divider, one quotient bit per cycle:
//   setup states for the multiply, add and range check, then one iteration
//   per quotient bit for each channel; a zero normalizer skips the divider.
//   Spectra long enough to cover that divider work stream without stalls;
//   shorter ones are throttled by the divider once the queue fills. The last
//   sample passes the multiply stages and the queue, then the divider, before
//   its result reaches the output register. Reset clears all sums, the queue
//   and the output valid. When the receiver stalls, the result holds in the
//   output register while the divider finishes the next spectrum; then the
//   queue fills and s_tready drops on the next last sample.
module spectral_to_xyz_tristimulus (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // reflectance, illuminant, observer_x, observer_y, observer_z
	input  logic        s_tlast,   // last_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // tri_x, tri_y, tri_z
	output logic [1:0]  m_tuser    // norm_zero, clipped
);
	import stc_pkg::*;

	logic       push, pop;
	sums_t      push_data, head;
	fifo_stat_t q_stat;

	// Sample intake and accumulation
	stc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// Queue of finished spectra
	stc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// Normalizing divider and result register
	stc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- design/stc_checker.sv -----
// Port-level checks for the tristimulus block, bound to its top level.
// Sees only the top-level ports; no package dependency.
module stc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [79:0] s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// Hold a stalled result
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Zero normalizer gives zero outputs and never a clip
	a_zero_norm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == 48'd0) && !m_tuser[1])
		else $error("zero normalizer result not cleared");

	// A clip shows as at least one saturated channel
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata[15:0] == 16'hFFFF) ||
			(m_tdata[31:16] == 16'hFFFF) || (m_tdata[47:32] == 16'hFFFF))
		else $error("clip flag without a saturated channel");

endmodule

bind spectral_to_xyz_tristimulus stc_checker u_stc_checker (.*);

// ----- bench/spectral_to_xyz_tristimulus_tb.sv -----
// Self-checking bench for spectral_to_xyz_tristimulus: streams spectra and compares XYZ results.
// The bench carries its own accumulate-and-divide prediction of the block.
// Depends on stc_pkg for MAX_SAMPLES and on the block's top level.
module spectral_to_xyz_tristimulus_tb;
	import stc_pkg::*;

	localparam int RANDOM_SAMPLES = 1450;
	localparam int MAX_GAP        = 14;
	localparam int DRAIN_CYCLES   = 150;
	localparam int CYCLE_LIMIT    = 600000;
	localparam int N_DIRECTED     = 15;

	// Accumulator ceilings: MAX_SAMPLES full-scale terms
	localparam bit [63:0] CAP_PRODUCT = 64'(MAX_SAMPLES) * 64'd65535 * 64'd65535 * 64'd65535;
	localparam bit [63:0] CAP_NORMAL  = 64'(MAX_SAMPLES) * 64'd65535 * 64'd65535;

	typedef struct packed {
		logic [15:0] refl;
		logic [15:0] illum;
		logic [15:0] ox;
		logic [15:0] oy;
		logic [15:0] oz;
		logic        last;
	} sample_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic        norm_zero;
		logic        clipped;
	} xyz_t;

	// One directed sample; typed result only where it is obvious
	typedef struct packed {
		logic [15:0] refl;
		logic [15:0] illum;
		logic [15:0] ox;
		logic [15:0] oy;
		logic [15:0] oz;
		logic        last;
		logic        typed;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic        norm_zero;
		logic        clipped;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;   // reflectance, illuminant, observer_x, observer_y, observer_z
	logic        s_tlast;   // last_sample
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // tri_x, tri_y, tri_z
	logic [1:0]  m_tuser;   // norm_zero, clipped

	// Prediction state: running sums of the current spectrum
	bit [63:0] acc_x, acc_y, acc_z, acc_norm;
	xyz_t      expected_xyz [$];

	int  errors;
	int  samples_sent;
	int  spectra_sent;
	int  results_seen;
	int  zero_norm_seen;
	int  clipped_seen;
	int  cycle_count;
	bit  src_burst;
	bit  sink_burst;

	row_t directed_rows [0:N_DIRECTED-1] = '{
		// all zero: zero normalizer
		'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			1'b1, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0},
		// perfect reflector under unit light, unit observer: 100.0
		'{16'd32768, 16'd128, 16'd16384, 16'd16384, 16'd16384, 1'b1,
			1'b1, 16'd25600, 16'd25600, 16'd25600, 1'b0, 1'b0},
		// every field at full scale
		'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
			1'b1, 16'd51199, 16'd51199, 16'd51199, 1'b0, 1'b0},
		// tiny ybar: X saturates
		'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0000, 1'b1,
			1'b1, 16'd65535, 16'd51199, 16'd0, 1'b0, 1'b1},
		// ybar zero: zero normalizer despite nonzero products
		'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1,
			1'b1, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0},
		// illuminant zero: zero normalizer
		'{16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
			1'b1, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0},
		// black sample: nonzero normalizer, zero output
		'{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
			1'b1, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0},
		// three-sample spectrum
		'{16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b0,
			1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0},
		'{16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF, 16'h0001, 1'b0,
			1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0},
		'{16'd12345, 16'd40000, 16'd30000, 16'd20000, 16'd10000, 1'b1,
			1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0},
		// two-sample spectrum with opposite X and Z weights
		'{16'd32768, 16'd128, 16'h0000, 16'd16384, 16'hFFFF, 1'b0,
			1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0},
		'{16'd32768, 16'd128, 16'hFFFF, 16'd16384, 16'h0000, 1'b1,
			1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0},
		// smallest nonzero terms
		'{16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b1,
			1'b1, 16'd1, 16'd1, 16'd1, 1'b0, 1'b0},
		// rounding ties go upward: 12.5 -> 13, 37.5 -> 38
		'{16'h0001, 16'h0001, 16'd16, 16'h0001, 16'd48, 1'b1,
			1'b1, 16'd13, 16'd1, 16'd38, 1'b0, 1'b0},
		// mid-range single sample
		'{16'h8000, 16'h4000, 16'h2000, 16'h1000, 16'h0800, 1'b1,
			1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0}
	};

	spectral_to_xyz_tristimulus dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Guard against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycle_count, expected_xyz.size());
			$display("FAIL");
			$finish;
		end
	end

	function automatic bit [63:0] sat_add(bit [63:0] acc, bit [63:0] add, bit [63:0] cap);
		if (acc >= cap || add > cap - acc)
			return cap;
		return acc + add;
	endfunction

	// Scale one sum to Q8.8 against the normalizer, round half up, saturate
	function automatic logic [15:0] scale_to_q8(bit [63:0] sum, bit [63:0] den, inout logic clip);
		bit [63:0] q;
		q = (sum * 64'd100 + den / 2) / den;
		if (q > 64'd65535) begin
			clip = 1'b1;
			return 16'hFFFF;
		end
		return q[15:0];
	endfunction

	// Add one sample to the sums; on the last one, produce XYZ and clear
	function automatic bit fold_sample(input sample_t smp, output xyz_t res);
		bit [63:0] ri;
		bit [63:0] den;
		logic      clip;
		ri       = 64'(smp.refl) * 64'(smp.illum);
		acc_x    = sat_add(acc_x, ri * 64'(smp.ox), CAP_PRODUCT);
		acc_y    = sat_add(acc_y, ri * 64'(smp.oy), CAP_PRODUCT);
		acc_z    = sat_add(acc_z, ri * 64'(smp.oz), CAP_PRODUCT);
		acc_norm = sat_add(acc_norm, 64'(smp.oy) * 64'(smp.illum), CAP_NORMAL);
		res = '0;
		if (!smp.last)
			return 1'b0;
		if (acc_norm == 0) begin
			res.norm_zero = 1'b1;
		end else begin
			clip  = 1'b0;
			den   = acc_norm * 64'd128;
			res.x = scale_to_q8(acc_x, den, clip);
			res.y = scale_to_q8(acc_y, den, clip);
			res.z = scale_to_q8(acc_z, den, clip);
			res.clipped = clip;
		end
		acc_x    = 0;
		acc_y    = 0;
		acc_z    = 0;
		acc_norm = 0;
		return 1'b1;
	endfunction

	// Offer one sample, hold until the transfer, then fold it into the prediction
	task automatic push_sample(input sample_t smp, input bit typed, input xyz_t typed_res);
		int   gap;
		xyz_t want;
		gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {smp.oz, smp.oy, smp.ox, smp.illum, smp.refl};
		s_tlast  <= smp.last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		samples_sent++;
		if (fold_sample(smp, want)) begin
			spectra_sent++;
			expected_xyz.push_back(typed ? typed_res : want);
		end
	endtask

	function automatic logic [15:0] pick_level();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	// Result side: random stalls, compare each transfer with the oldest prediction
	initial begin
		int   stall;
		xyz_t got;
		xyz_t want;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				sink_burst = !sink_burst;
			stall = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser[0], m_tuser[1]};
			results_seen++;
			if (got.norm_zero)
				zero_norm_seen++;
			if (got.clipped)
				clipped_seen++;
			if (expected_xyz.size() == 0) begin
				$display("%0t: result with no spectrum pending: x=%0d y=%0d z=%0d nz=%0b clip=%0b",
					$time, got.x, got.y, got.z, got.norm_zero, got.clipped);
				errors++;
			end else begin
				want = expected_xyz.pop_front();
				if (got.x !== want.x) begin
					$display("%0t: tri_x expected %0d got %0d", $time, want.x, got.x);
					errors++;
				end
				if (got.y !== want.y) begin
					$display("%0t: tri_y expected %0d got %0d", $time, want.y, got.y);
					errors++;
				end
				if (got.z !== want.z) begin
					$display("%0t: tri_z expected %0d got %0d", $time, want.z, got.z);
					errors++;
				end
				if (got.norm_zero !== want.norm_zero) begin
					$display("%0t: norm_zero expected %0b got %0b",
						$time, want.norm_zero, got.norm_zero);
					errors++;
				end
				if (got.clipped !== want.clipped) begin
					$display("%0t: clipped expected %0b got %0b",
						$time, want.clipped, got.clipped);
					errors++;
				end
			end
		end
	end

	// Sample side: directed table, then random spectra
	initial begin
		sample_t smp;
		xyz_t    typed_res;
		row_t    row;
		int      kind;
		int      len;
		int      random_sent;
		bit      kill_illum;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		acc_x       = 0;
		acc_y       = 0;
		acc_z       = 0;
		acc_norm    = 0;
		errors      = 0;
		cycle_count = 0;
		src_burst   = 1'b0;
		sink_burst  = 1'b0;
		random_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int i = 0; i < N_DIRECTED; i++) begin
			row       = directed_rows[i];
			smp       = {row.refl, row.illum, row.ox, row.oy, row.oz, row.last};
			typed_res = {row.x, row.y, row.z, row.norm_zero, row.clipped};
			push_sample(smp, row.typed, typed_res);
		end

		// Random spectra: mostly short, some zero-normalizer, some overlong
		while (random_sent < RANDOM_SAMPLES) begin
			kind       = $urandom_range(0, 19);
			src_burst  = ($urandom_range(0, 3) == 0);
			kill_illum = $urandom_range(0, 1);
			case (kind)
				0: len = $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 26);
				1: len = $urandom_range(1, 8);
				2: len = 1;
				default: len = $urandom_range(2, 24);
			endcase
			for (int i = 0; i < len; i++) begin
				if (kind == 0) begin
					smp.refl  = 16'($urandom_range(49152, 65535));
					smp.illum = 16'($urandom_range(49152, 65535));
					smp.ox    = 16'($urandom_range(49152, 65535));
					smp.oy    = 16'($urandom_range(49152, 65535));
					smp.oz    = 16'($urandom_range(49152, 65535));
				end else begin
					smp.refl  = pick_level();
					smp.illum = pick_level();
					smp.ox    = pick_level();
					smp.oy    = pick_level();
					smp.oz    = pick_level();
				end
				if (kind == 1) begin
					if (kill_illum)
						smp.illum = 16'h0000;
					else
						smp.oy = 16'h0000;
				end
				smp.last = (i == len - 1);
				push_sample(smp, 1'b0, '0);
				random_sent++;
			end
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		// Drain: every prediction answered, then let stray results show up
		while (expected_xyz.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Streamed %0d samples in %0d spectra; checked %0d results",
			samples_sent, spectra_sent, results_seen);
		$display("  %0d with zero normalizer, %0d saturated, %0d mismatches",
			zero_norm_seen, clipped_seen, errors);
		if (errors == 0 && expected_xyz.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
